[sv/point_cloud_voxel_occupancy_top_macros.svh]
// Assertion macros of the voxel occupancy RTL, used by the sequencer.
`ifndef POINT_CLOUD_VOXEL_OCCUPANCY_TOP_MACROS_SVH
`define POINT_CLOUD_VOXEL_OCCUPANCY_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PCVO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PCVO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pcvo_pkg.sv]
// Shared constants, types and codes of the voxel occupancy block.
`default_nettype none
package pcvo_pkg;

    // Grid storage: cells packed into rows of one memory word each.
    localparam int GRID_CELLS = 4096;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int ROW_BITS   = 32;
    localparam int ROW_SEL_W  = $clog2(ROW_BITS);
    localparam int ROWS       = GRID_CELLS / ROW_BITS;
    localparam int ROW_W      = $clog2(ROWS);

    // Field and register widths.
    localparam int COORD_W    = 16;
    localparam int HALF_W     = 15;
    localparam int IVS_W      = 16;
    localparam int STRIDE_W   = 13;
    localparam int CELL_W     = 12;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BOUND_W    = (ADDR_W + 1 > STRIDE_W) ? ADDR_W + 1 : STRIDE_W;

    // Shared multiply-add datapath.
    localparam int MUL_W      = 2 * IVS_W;
    localparam int ACC_W      = 32;
    localparam int FRAC_SHIFT = 16;

    // Register reset values.
    localparam logic [HALF_W-1:0]   RST_HALF_X     = HALF_W'(1280);
    localparam logic [HALF_W-1:0]   RST_HALF_Y     = HALF_W'(1280);
    localparam logic [HALF_W-1:0]   RST_HALF_Z     = HALF_W'(512);
    localparam logic [IVS_W-1:0]    RST_INV_VOXEL  = IVS_W'(256);
    localparam logic [STRIDE_W-1:0] RST_CELLS_Z    = STRIDE_W'(4);
    localparam logic [STRIDE_W-1:0] RST_STRIDE_X   = STRIDE_W'(40);
    localparam logic [STRIDE_W-1:0] RST_CELLS_USED = STRIDE_W'(400);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT,
        ACT_CLEAR,
        ACT_READ,
        ACT_NONE
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X,
        REG_HALF_Y,
        REG_HALF_Z,
        REG_INV_VOXEL,
        REG_CELLS_Z,
        REG_STRIDE_X,
        REG_CELLS_USED
    } t_reg_idx;

    typedef struct packed {
        logic [HALF_W-1:0]   half_x;
        logic [HALF_W-1:0]   half_y;
        logic [HALF_W-1:0]   half_z;
        logic [IVS_W-1:0]    inv_voxel;
        logic [STRIDE_W-1:0] cells_z;
        logic [STRIDE_W-1:0] stride_x;
        logic [STRIDE_W-1:0] cells_used;
    } t_cfg;

    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_row;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_row;
        logic [ROW_BITS-1:0] wr_data;
    } t_grid_req;

    typedef struct packed {
        logic [IVS_W-1:0] a;
        logic [IVS_W-1:0] b;
        logic [ACC_W-1:0] addend;
        logic             scale;
    } t_mac_req;

endpackage
`default_nettype wire

[sv/pcvo_ifs.sv]
// Handshake channel interfaces: point requests, results and register writes.
`default_nettype none
interface pcvo_item_if import pcvo_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [CELL_W-1:0]          query_cell;

    modport source (output valid, action, coord_x, coord_y, coord_z, query_cell,
                    input ready);
    modport sink   (input valid, action, coord_x, coord_y, coord_z, query_cell,
                    output ready);
endinterface

interface pcvo_result_if import pcvo_pkg::*;;
    logic              valid;
    logic              ready;
    logic              inside_grid;
    logic [CELL_W-1:0] cell_number;
    logic              occupied;

    modport source (output valid, inside_grid, cell_number, occupied, input ready);
    modport sink   (input valid, inside_grid, cell_number, occupied, output ready);
endinterface

interface pcvo_cfg_if import pcvo_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/pcvo_mac.sv]
// Shared multiply-add unit: addend + a*b, product optionally scaled down by 2^16.
`default_nettype none
module pcvo_mac import pcvo_pkg::*; (
    input  t_mac_req         i_req,
    output logic [ACC_W-1:0] o_sum
);

    logic [MUL_W-1:0] prod;
    logic [MUL_W-1:0] term;

    assign prod  = MUL_W'(i_req.a) * MUL_W'(i_req.b);
    // Q8.8 times 1/256 m leaves 16 fraction bits: drop them to floor.
    assign term  = i_req.scale ? (prod >> FRAC_SHIFT) : prod;
    assign o_sum = i_req.addend + ACC_W'(term);

endmodule
`default_nettype wire

[sv/pcvo_grid.sv]
// Occupancy bit store: one row of cells per word, with per-row valid bits.
`default_nettype none
module pcvo_grid import pcvo_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_grid_req           i_req,
    output logic [ROW_BITS-1:0] o_rdata
);

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rdata;
    logic [ROWS-1:0]     r_valid;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_row];
        end
    end

    // A row never written since reset reads as all empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_row] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_row];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule
`default_nettype wire

[sv/pcvo_ctrl.sv]
// Sequencer: range check, index build on the shared unit, grid access, result register.
`default_nettype none
module pcvo_ctrl import pcvo_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg_regs,
    pcvo_item_if.sink           i_item,
    pcvo_result_if.source       o_result,
    output t_mac_req            o_mac_req,
    input  logic [ACC_W-1:0]    i_mac_sum,
    output t_grid_req           o_grid_req,
    input  logic [ROW_BITS-1:0] i_grid_rdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_ACC_X,
        S_MUL_Y,
        S_ACC_Y,
        S_MUL_Z,
        S_ACC_Z,
        S_CHECK,
        S_SET,
        S_QUERY,
        S_FETCH,
        S_CLR_RD,
        S_CLR_WR,
        S_PUSH
    } t_state;

    function automatic logic [COORD_W:0] coord_mag(input logic [COORD_W-1:0] c);
        logic [COORD_W:0] e;
        e = {c[COORD_W-1], c};
        return c[COORD_W-1] ? (~e + 1'b1) : e;
    endfunction

    function automatic logic [COORD_W-1:0] coord_off(input logic [COORD_W-1:0] c,
                                                     input logic [HALF_W-1:0]  h);
        logic [COORD_W:0] s;
        s = {c[COORD_W-1], c} + (COORD_W+1)'(h);
        return s[COORD_W-1:0];
    endfunction

    t_state              r_state,      n_state;
    logic [COORD_W-1:0]  r_off_x,      n_off_x;
    logic [COORD_W-1:0]  r_off_y,      n_off_y;
    logic [COORD_W-1:0]  r_off_z,      n_off_z;
    logic [CELL_W-1:0]   r_query,      n_query;
    logic [IVS_W-1:0]    r_cnt,        n_cnt;
    logic [ACC_W-1:0]    r_acc,        n_acc;
    logic [ROW_W-1:0]    r_row,        n_row;
    logic                r_res_inside, n_res_inside;
    logic [CELL_W-1:0]   r_res_cell,   n_res_cell;
    logic                r_res_occ,    n_res_occ;
    logic                r_out_valid,  n_out_valid;
    logic                r_out_inside, n_out_inside;
    logic [CELL_W-1:0]   r_out_cell,   n_out_cell;
    logic                r_out_occ,    n_out_occ;

    logic [BOUND_W-1:0]  used_ext;
    logic [BOUND_W-1:0]  bound;
    logic                in_x, in_y, in_z;
    logic [BOUND_W-1:0]  row_start;
    logic [BOUND_W-1:0]  next_start;
    logic [BOUND_W-1:0]  clr_lim;
    logic [ROW_BITS-1:0] clr_mask;
    logic [ADDR_W-1:0]   cell_addr;
    logic [ADDR_W-1:0]   query_addr;
    logic                query_ok;

    // Effective bound: the used count, capped at the grid capacity.
    assign used_ext = BOUND_W'(i_cfg_regs.cells_used);
    assign bound    = (used_ext < BOUND_W'(GRID_CELLS)) ? used_ext : BOUND_W'(GRID_CELLS);

    assign in_x = coord_mag(i_item.coord_x) < (COORD_W+1)'(i_cfg_regs.half_x);
    assign in_y = coord_mag(i_item.coord_y) < (COORD_W+1)'(i_cfg_regs.half_y);
    assign in_z = coord_mag(i_item.coord_z) < (COORD_W+1)'(i_cfg_regs.half_z);

    assign row_start  = BOUND_W'(r_row) << ROW_SEL_W;
    assign next_start = BOUND_W'({1'b0, r_row} + (ROW_W+1)'(1)) << ROW_SEL_W;
    assign clr_lim    = bound - row_start;

    always_comb begin
        for (int b = 0; b < ROW_BITS; b++) begin
            clr_mask[b] = BOUND_W'(b) < clr_lim;
        end
    end

    assign cell_addr  = r_acc[ADDR_W-1:0];
    assign query_addr = ADDR_W'(r_query);
    assign query_ok   = BOUND_W'(r_query) < bound;

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.inside_grid = r_out_inside;
    assign o_result.cell_number = r_out_cell;
    assign o_result.occupied    = r_out_occ;

    // Operand routing for the shared multiply-add unit.
    always_comb begin
        o_mac_req = '0;
        case (r_state)
            S_MUL_X: begin
                o_mac_req.a     = r_off_x;
                o_mac_req.b     = i_cfg_regs.inv_voxel;
                o_mac_req.scale = 1'b1;
            end
            S_ACC_X: begin
                o_mac_req.a = r_cnt;
                o_mac_req.b = IVS_W'(i_cfg_regs.stride_x);
            end
            S_MUL_Y: begin
                o_mac_req.a     = r_off_y;
                o_mac_req.b     = i_cfg_regs.inv_voxel;
                o_mac_req.scale = 1'b1;
            end
            S_ACC_Y: begin
                o_mac_req.a      = r_cnt;
                o_mac_req.b      = IVS_W'(i_cfg_regs.cells_z);
                o_mac_req.addend = r_acc;
            end
            S_MUL_Z: begin
                o_mac_req.a     = r_off_z;
                o_mac_req.b     = i_cfg_regs.inv_voxel;
                o_mac_req.scale = 1'b1;
            end
            S_ACC_Z: begin
                o_mac_req.a      = r_cnt;
                o_mac_req.b      = IVS_W'(1);
                o_mac_req.addend = r_acc;
            end
            default: begin
                o_mac_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_off_x      = r_off_x;
        n_off_y      = r_off_y;
        n_off_z      = r_off_z;
        n_query      = r_query;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_row        = r_row;
        n_res_inside = r_res_inside;
        n_res_cell   = r_res_cell;
        n_res_occ    = r_res_occ;
        n_out_valid  = r_out_valid;
        n_out_inside = r_out_inside;
        n_out_cell   = r_out_cell;
        n_out_occ    = r_out_occ;
        o_grid_req   = '0;

        // Drop the held result once the consumer takes it.
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_off_x      = coord_off(i_item.coord_x, i_cfg_regs.half_x);
                    n_off_y      = coord_off(i_item.coord_y, i_cfg_regs.half_y);
                    n_off_z      = coord_off(i_item.coord_z, i_cfg_regs.half_z);
                    n_query      = i_item.query_cell;
                    n_res_inside = 1'b0;
                    n_res_cell   = '0;
                    n_res_occ    = 1'b0;
                    case (i_item.action)
                        ACT_INSERT: begin
                            n_state = (in_x && in_y && in_z) ? S_MUL_X : S_PUSH;
                        end
                        ACT_CLEAR: begin
                            n_row   = '0;
                            n_state = S_CLR_RD;
                        end
                        ACT_READ: begin
                            n_state = S_QUERY;
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_MUL_X: begin
                n_cnt   = i_mac_sum[IVS_W-1:0];
                n_state = S_ACC_X;
            end
            S_ACC_X: begin
                n_acc   = i_mac_sum;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                n_cnt   = i_mac_sum[IVS_W-1:0];
                n_state = S_ACC_Y;
            end
            S_ACC_Y: begin
                n_acc   = i_mac_sum;
                n_state = S_MUL_Z;
            end
            S_MUL_Z: begin
                n_cnt   = i_mac_sum[IVS_W-1:0];
                n_state = S_ACC_Z;
            end
            S_ACC_Z: begin
                n_acc   = i_mac_sum;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_acc < ACC_W'(bound)) begin
                    o_grid_req.rd_en  = 1'b1;
                    o_grid_req.rd_row = cell_addr[ADDR_W-1:ROW_SEL_W];
                    n_state           = S_SET;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_SET: begin
                o_grid_req.wr_en   = 1'b1;
                o_grid_req.wr_row  = cell_addr[ADDR_W-1:ROW_SEL_W];
                o_grid_req.wr_data = i_grid_rdata |
                                     (ROW_BITS'(1) << cell_addr[ROW_SEL_W-1:0]);
                n_res_inside       = 1'b1;
                n_res_cell         = r_acc[CELL_W-1:0];
                n_state            = S_PUSH;
            end
            S_QUERY: begin
                o_grid_req.rd_en  = 1'b1;
                o_grid_req.rd_row = query_addr[ADDR_W-1:ROW_SEL_W];
                n_state           = S_FETCH;
            end
            S_FETCH: begin
                n_res_cell = r_query;
                n_res_occ  = query_ok && i_grid_rdata[query_addr[ROW_SEL_W-1:0]];
                n_state    = S_PUSH;
            end
            S_CLR_RD: begin
                o_grid_req.rd_en  = 1'b1;
                o_grid_req.rd_row = r_row;
                n_state           = S_CLR_WR;
            end
            S_CLR_WR: begin
                o_grid_req.wr_en   = 1'b1;
                o_grid_req.wr_row  = r_row;
                o_grid_req.wr_data = i_grid_rdata & ~clr_mask;
                if ((r_row != ROW_W'(ROWS - 1)) && (next_start < bound)) begin
                    n_row   = r_row + 1'b1;
                    n_state = S_CLR_RD;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // Hold here until the result register is free.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_res_inside;
                    n_out_cell   = r_res_cell;
                    n_out_occ    = r_res_occ;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_off_x      <= n_off_x;
        r_off_y      <= n_off_y;
        r_off_z      <= n_off_z;
        r_query      <= n_query;
        r_cnt        <= n_cnt;
        r_acc        <= n_acc;
        r_row        <= n_row;
        r_res_inside <= n_res_inside;
        r_res_cell   <= n_res_cell;
        r_res_occ    <= n_res_occ;
        r_out_inside <= n_out_inside;
        r_out_cell   <= n_out_cell;
        r_out_occ    <= n_out_occ;
    end

`include "point_cloud_voxel_occupancy_top_macros.svh"

    `PCVO_ASSERT_NOW(a_set_in_bound, r_state == S_SET, r_acc < ACC_W'(bound),
                     "cell set at an index beyond the used cells")
    `PCVO_ASSERT_NEXT(a_set_reports, r_state == S_SET,
                      (r_state == S_PUSH) && r_res_inside,
                      "set cell not reported as inside")
    `PCVO_ASSERT_NOW(a_clear_in_bound, (r_state == S_CLR_WR) && (r_row != '0),
                     row_start < bound, "clear sweep ran past the used cells")
    `PCVO_ASSERT_NOW(a_one_grid_access, 1'b1, !(o_grid_req.rd_en && o_grid_req.wr_en),
                     "grid read and write in the same cycle")

endmodule
`default_nettype wire

[sv/point_cloud_voxel_occupancy_top.sv]
// Top level of the voxel occupancy grid builder: register file and unit wiring.
`default_nettype none
// Builds a 3-D occupancy bitmap of 4096 one-bit cells from points given in signed
// 1/256 m coordinates. Each request carries an action: insert a point, clear the
// used cells, read one cell, or do nothing; each gives exactly one result. An
// insert checks |c| < half extent on all three axes, then a single shared
// multiply-add unit forms the three floored axis counts (offset times the Q8.8
// inverse voxel size) and folds them into the linear index over six passes; no
// cell is set when the index lands at or beyond the bound. An outside point or
// the unused action goes straight to its result, a read does one registered row
// read of the grid memory, and a clear reads and rewrites one 32-cell row at a
// time through the single memory port, from the first row up to the bound, the
// used cell count capped at 4096. Per-row valid bits clear the whole grid at
// reset, so no clearing pass follows reset. The block takes one request at a
// time; a finished result waits in an output register while the next request
// is accepted, and a result still held there when the next one is done holds
// the sequencer until the result side takes it.
// Configuration writes are always taken and must only come while the block is
// idle.
module point_cloud_voxel_occupancy_top import pcvo_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcvo_item_if.sink      i_item,
    pcvo_result_if.source  o_result,
    pcvo_cfg_if.sink       i_cfg
);

    t_cfg                r_cfg;
    t_mac_req            mac_req;
    logic [ACC_W-1:0]    mac_sum;
    t_grid_req           grid_req;
    logic [ROW_BITS-1:0] grid_rdata;

    // Register writes never stall; an index past the last register is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_x     <= RST_HALF_X;
            r_cfg.half_y     <= RST_HALF_Y;
            r_cfg.half_z     <= RST_HALF_Z;
            r_cfg.inv_voxel  <= RST_INV_VOXEL;
            r_cfg.cells_z    <= RST_CELLS_Z;
            r_cfg.stride_x   <= RST_STRIDE_X;
            r_cfg.cells_used <= RST_CELLS_USED;
        end else if (i_cfg.valid) begin
            // Keep only the low bits that each register holds.
            case (i_cfg.index)
                REG_HALF_X:     r_cfg.half_x     <= i_cfg.data[HALF_W-1:0];
                REG_HALF_Y:     r_cfg.half_y     <= i_cfg.data[HALF_W-1:0];
                REG_HALF_Z:     r_cfg.half_z     <= i_cfg.data[HALF_W-1:0];
                REG_INV_VOXEL:  r_cfg.inv_voxel  <= i_cfg.data[IVS_W-1:0];
                REG_CELLS_Z:    r_cfg.cells_z    <= i_cfg.data[STRIDE_W-1:0];
                REG_STRIDE_X:   r_cfg.stride_x   <= i_cfg.data[STRIDE_W-1:0];
                REG_CELLS_USED: r_cfg.cells_used <= i_cfg.data[STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: range check, index build, grid access and the result register.
    pcvo_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_regs   (r_cfg),
        .i_item       (i_item),
        .o_result     (o_result),
        .o_mac_req    (mac_req),
        .i_mac_sum    (mac_sum),
        .o_grid_req   (grid_req),
        .i_grid_rdata (grid_rdata)
    );

    // The one multiplier of the block, reused for every count and stride term.
    pcvo_mac u_mac (
        .i_req (mac_req),
        .o_sum (mac_sum)
    );

    // Occupancy storage: 32-cell rows, registered read, row valid bits.
    pcvo_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (grid_req),
        .o_rdata (grid_rdata)
    );

endmodule
`default_nettype wire
